/* hw/rtl/zcdp_pkg.sv */
// ----------------------------------------------------------------------------
// zcdp_pkg
// Shared types and constants of the central directory parser: the result
// record, the parser phases, result kinds, error codes and header layout.
// ----------------------------------------------------------------------------
package zcdp_pkg;

    localparam int CFG_DW = 32;
    localparam int CFG_IW = 1;

    localparam logic [CFG_IW-1:0] CFG_BYTES_AVAIL = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_ENTRY_COUNT = 1'd1;

    localparam logic [31:0] CENTRAL_SIG = 32'h0201_4b50;
    localparam logic [31:0] ZIP64_MARK  = 32'hFFFF_FFFF;
    localparam int          HDR_LEN     = 46;

    // byte positions inside the fixed header
    localparam logic [5:0] HDR_SIG_LAST   = 6'd3;
    localparam logic [5:0] HDR_METHOD     = 6'd10;
    localparam logic [5:0] HDR_CRC        = 6'd16;
    localparam logic [5:0] HDR_COMP       = 6'd20;
    localparam logic [5:0] HDR_UNCOMP     = 6'd24;
    localparam logic [5:0] HDR_NAME_LEN   = 6'd28;
    localparam logic [5:0] HDR_EXTRA_LEN  = 6'd30;
    localparam logic [5:0] HDR_COMM_LEN   = 6'd32;
    localparam logic [5:0] HDR_LOCAL_OFF  = 6'd42;
    localparam logic [5:0] HDR_LAST       = 6'd45;

    localparam logic ACT_START = 1'b0;

    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OFFSET    = 3'd1;
    localparam logic [2:0] ERR_MALFORMED = 3'd2;
    localparam logic [2:0] ERR_ZIP64     = 3'd3;
    localparam logic [2:0] ERR_NAME      = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_NAME   = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] entry_index;
        logic [15:0] method;
        logic [31:0] crc_value;
        logic [31:0] comp_bytes;
        logic [31:0] uncomp_bytes;
        logic [31:0] local_offset;
        logic [15:0] name_len;
        logic [7:0]  name_byte;
        logic        name_last;
        logic [2:0]  error_code;
    } res_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

/* hw/rtl/zcdp_in_if.sv */
// ----------------------------------------------------------------------------
// zcdp_in_if
// Input channel of the parser: start or directory byte items.
// ----------------------------------------------------------------------------
interface zcdp_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

/* hw/rtl/zcdp_out_if.sv */
// ----------------------------------------------------------------------------
// zcdp_out_if
// Output channel of the parser: entry records, name bytes, completion, errors.
// ----------------------------------------------------------------------------
interface zcdp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] entry_index;
    logic [15:0] method;
    logic [31:0] crc_value;
    logic [31:0] comp_bytes;
    logic [31:0] uncomp_bytes;
    logic [31:0] local_offset;
    logic [15:0] name_len;
    logic [7:0]  name_byte;
    logic        name_last;
    logic [2:0]  error_code;

    modport source (
        output valid, output result_kind, output entry_index, output method,
        output crc_value, output comp_bytes, output uncomp_bytes,
        output local_offset, output name_len, output name_byte,
        output name_last, output error_code, input ready
    );
    modport sink (
        input valid, input result_kind, input entry_index, input method,
        input crc_value, input comp_bytes, input uncomp_bytes,
        input local_offset, input name_len, input name_byte,
        input name_last, input error_code, output ready
    );
endinterface

/* hw/rtl/zcdp_front.sv */
// ----------------------------------------------------------------------------
// zcdp_front
// Byte parser: holds the configuration, walks each fixed header, name, extra
// and comment field, and produces up to two result records per item.
// ----------------------------------------------------------------------------
module zcdp_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [zcdp_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [zcdp_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                         accept,
    input  logic                         action,
    input  logic [7:0]                   data_byte,
    output zcdp_pkg::push_t              push,
    output zcdp_pkg::res_t               res0,
    output zcdp_pkg::res_t               res1
);
    import zcdp_pkg::*;

    logic [31:0] avail_reg;
    logic [15:0] count_reg;

    phase_t      phase_reg, phase_next;
    logic [5:0]  hdr_pos_reg, hdr_pos_next;
    logic [33:0] consumed_reg, consumed_next;
    logic [15:0] entry_reg, entry_next;
    logic [23:0] sig_reg, sig_next;
    logic [15:0] method_reg, method_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] comp_reg, comp_next;
    logic [31:0] uncomp_reg, uncomp_next;
    logic [31:0] loff_reg, loff_next;
    logic [15:0] nlen_reg, nlen_next;
    logic [15:0] xlen_reg, xlen_next;
    logic [15:0] clen_reg, clen_next;
    logic [15:0] name_rem_reg, name_rem_next;
    logic [16:0] skip_rem_reg, skip_rem_next;

    logic [33:0] consumed_inc;
    logic [15:0] oe_entry;
    logic [33:0] oe_consumed;
    logic        oe_done;
    logic        oe_bad;
    logic        open_req;
    res_t        open_res;
    logic [1:0]  lane4;
    logic [1:0]  off_lane;
    logic        zip64_hit;
    logic        name_over;
    logic [16:0] skip_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg <= '0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTES_AVAIL: avail_reg <= cfg_wdata;
                CFG_ENTRY_COUNT: count_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign consumed_inc = consumed_reg + 34'd1;
    assign oe_entry     = (action == ACT_START) ? 16'd0 : entry_reg + 16'd1;
    assign oe_consumed  = (action == ACT_START) ? 34'd0 : consumed_inc;
    assign oe_done      = oe_entry >= count_reg;
    assign oe_bad       = ({1'b0, oe_consumed} + 35'(HDR_LEN)) > {3'b000, avail_reg};
    assign lane4        = hdr_pos_reg[1:0];
    assign off_lane     = 2'(hdr_pos_reg - HDR_LOCAL_OFF);

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_pos_next  = hdr_pos_reg;
        consumed_next = consumed_reg;
        entry_next    = entry_reg;
        sig_next      = sig_reg;
        method_next   = method_reg;
        crc_next      = crc_reg;
        comp_next     = comp_reg;
        uncomp_next   = uncomp_reg;
        loff_next     = loff_reg;
        nlen_next     = nlen_reg;
        xlen_next     = xlen_reg;
        clen_next     = clen_reg;
        name_rem_next = name_rem_reg;
        skip_rem_next = skip_rem_reg;
        push          = '0;
        res0          = '0;
        res1          = '0;
        open_req      = 1'b0;
        open_res      = '0;
        zip64_hit     = 1'b0;
        name_over     = 1'b0;
        skip_sum      = '0;

        if (accept)
        begin
            if (action == ACT_START)
            begin
                phase_next    = PH_IDLE;
                hdr_pos_next  = '0;
                consumed_next = '0;
                entry_next    = '0;
                sig_next      = '0;
                name_rem_next = '0;
                skip_rem_next = '0;
                if (avail_reg == 32'd0)
                begin
                    push.first       = 1'b1;
                    res0.result_kind = KIND_ERROR;
                    res0.error_code  = ERR_OFFSET;
                end
                else
                begin
                    open_req = 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_HEADER:
                    begin
                        consumed_next = consumed_inc;
                        if (hdr_pos_reg <= HDR_SIG_LAST)
                            sig_next = {data_byte, sig_reg[23:8]};
                        if (hdr_pos_reg >= HDR_METHOD && hdr_pos_reg < HDR_METHOD + 6'd2)
                            method_next[{hdr_pos_reg[0], 3'b000} +: 8] = data_byte;
                        if (hdr_pos_reg >= HDR_CRC && hdr_pos_reg < HDR_COMP)
                            crc_next[{lane4, 3'b000} +: 8] = data_byte;
                        if (hdr_pos_reg >= HDR_COMP && hdr_pos_reg < HDR_UNCOMP)
                            comp_next[{lane4, 3'b000} +: 8] = data_byte;
                        if (hdr_pos_reg >= HDR_UNCOMP && hdr_pos_reg < HDR_NAME_LEN)
                            uncomp_next[{lane4, 3'b000} +: 8] = data_byte;
                        if (hdr_pos_reg >= HDR_NAME_LEN && hdr_pos_reg < HDR_EXTRA_LEN)
                            nlen_next[{hdr_pos_reg[0], 3'b000} +: 8] = data_byte;
                        if (hdr_pos_reg >= HDR_EXTRA_LEN && hdr_pos_reg < HDR_COMM_LEN)
                            xlen_next[{hdr_pos_reg[0], 3'b000} +: 8] = data_byte;
                        if (hdr_pos_reg >= HDR_COMM_LEN && hdr_pos_reg < HDR_COMM_LEN + 6'd2)
                            clen_next[{hdr_pos_reg[0], 3'b000} +: 8] = data_byte;
                        if (hdr_pos_reg >= HDR_LOCAL_OFF)
                            loff_next[{off_lane, 3'b000} +: 8] = data_byte;

                        zip64_hit = comp_reg == ZIP64_MARK || uncomp_reg == ZIP64_MARK
                                    || loff_next == ZIP64_MARK;
                        name_over = ({1'b0, consumed_inc} + {19'd0, nlen_reg})
                                    > {3'b000, avail_reg};
                        skip_sum  = {1'b0, xlen_reg} + {1'b0, clen_reg};

                        if (hdr_pos_reg == HDR_SIG_LAST
                            && {data_byte, sig_reg} != CENTRAL_SIG)
                        begin
                            phase_next       = PH_IDLE;
                            push.first       = 1'b1;
                            res0.result_kind = KIND_ERROR;
                            res0.entry_index = entry_reg;
                            res0.error_code  = ERR_MALFORMED;
                        end
                        else if (hdr_pos_reg != HDR_LAST)
                        begin
                            hdr_pos_next = hdr_pos_reg + 6'd1;
                        end
                        else if (zip64_hit || name_over)
                        begin
                            phase_next       = PH_IDLE;
                            push.first       = 1'b1;
                            res0.result_kind = KIND_ERROR;
                            res0.entry_index = entry_reg;
                            res0.error_code  = zip64_hit ? ERR_ZIP64 : ERR_NAME;
                        end
                        else
                        begin
                            push.first             = 1'b1;
                            res0.result_kind       = KIND_ENTRY;
                            res0.entry_index       = entry_reg;
                            res0.method            = method_reg;
                            res0.crc_value         = crc_reg;
                            res0.comp_bytes        = comp_reg;
                            res0.uncomp_bytes      = uncomp_reg;
                            res0.local_offset      = loff_next;
                            res0.name_len          = nlen_reg;
                            hdr_pos_next           = '0;
                            skip_rem_next          = skip_sum;
                            name_rem_next          = nlen_reg;
                            if (nlen_reg != 16'd0)
                                phase_next = PH_NAME;
                            else if (skip_sum != 17'd0)
                                phase_next = PH_SKIP;
                            else
                                open_req = 1'b1;
                        end
                    end
                    PH_NAME:
                    begin
                        consumed_next    = consumed_inc;
                        name_rem_next    = name_rem_reg - 16'd1;
                        push.first       = 1'b1;
                        res0.result_kind = KIND_NAME;
                        res0.entry_index = entry_reg;
                        res0.name_len    = nlen_reg;
                        res0.name_byte   = data_byte;
                        res0.name_last   = name_rem_reg == 16'd1;
                        if (name_rem_reg == 16'd1)
                        begin
                            if (skip_rem_reg != 17'd0)
                                phase_next = PH_SKIP;
                            else
                                open_req = 1'b1;
                        end
                    end
                    PH_SKIP:
                    begin
                        consumed_next = consumed_inc;
                        skip_rem_next = skip_rem_reg - 17'd1;
                        if (skip_rem_reg == 17'd1)
                            open_req = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        // opening the next entry: completion, bounds error or a fresh header
        if (open_req)
        begin
            entry_next = oe_entry;
            if (oe_done)
            begin
                phase_next           = PH_IDLE;
                open_res.result_kind = KIND_DONE;
                open_res.entry_index = count_reg;
            end
            else if (oe_bad)
            begin
                phase_next           = PH_IDLE;
                open_res.result_kind = KIND_ERROR;
                open_res.entry_index = oe_entry;
                open_res.error_code  = ERR_MALFORMED;
            end
            else
            begin
                phase_next   = PH_HEADER;
                hdr_pos_next = '0;
                sig_next     = '0;
            end
            if (oe_done || oe_bad)
            begin
                if (push.first)
                begin
                    push.second = 1'b1;
                    res1        = open_res;
                end
                else
                begin
                    push.first = 1'b1;
                    res0       = open_res;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            hdr_pos_reg  <= '0;
            consumed_reg <= '0;
            entry_reg    <= '0;
            sig_reg      <= '0;
            method_reg   <= '0;
            crc_reg      <= '0;
            comp_reg     <= '0;
            uncomp_reg   <= '0;
            loff_reg     <= '0;
            nlen_reg     <= '0;
            xlen_reg     <= '0;
            clen_reg     <= '0;
            name_rem_reg <= '0;
            skip_rem_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_pos_reg  <= hdr_pos_next;
            consumed_reg <= consumed_next;
            entry_reg    <= entry_next;
            sig_reg      <= sig_next;
            method_reg   <= method_next;
            crc_reg      <= crc_next;
            comp_reg     <= comp_next;
            uncomp_reg   <= uncomp_next;
            loff_reg     <= loff_next;
            nlen_reg     <= nlen_next;
            xlen_reg     <= xlen_next;
            clen_reg     <= clen_next;
            name_rem_reg <= name_rem_next;
            skip_rem_reg <= skip_rem_next;
        end
    end

`ifndef SYNTH
    a_second_terminal : assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> (res1.result_kind == KIND_DONE || res1.result_kind == KIND_ERROR))
        else $error("second item of a step is neither completion nor error");
    a_error_idles : assert property (@(posedge clk) disable iff (!rst_n)
        (push.first && res0.result_kind == KIND_ERROR) |=> phase_reg == PH_IDLE)
        else $error("parser left idle after an error");
    a_hdr_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> hdr_pos_reg <= HDR_LAST)
        else $error("header position past the fixed header");
`endif

endmodule

/* hw/rtl/zcdp_queue.sv */
// ----------------------------------------------------------------------------
// zcdp_queue
// Result queue and output side: takes up to two records a cycle from the
// parser and hands them out one item at a time.
// ----------------------------------------------------------------------------
module zcdp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  zcdp_pkg::push_t  push,
    input  zcdp_pkg::res_t   res0,
    input  zcdp_pkg::res_t   res1,
    output logic             space_ok,
    zcdp_out_if.source       out_ch
);
    import zcdp_pkg::*;

    res_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic           pop;
    res_t           head;

    assign space_ok = count_reg <= QCW'(QDEPTH - 2);
    assign pop      = out_ch.valid && out_ch.ready;
    assign head     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.first)
            slot_reg[wr_ptr_reg] <= res0;
        if (push.second)
            slot_reg[QAW'(wr_ptr_reg + 1'b1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= QAW'(wr_ptr_reg + QAW'(push.first) + QAW'(push.second));
            if (pop)
                rd_ptr_reg <= QAW'(rd_ptr_reg + 1'b1);
            count_reg  <= QCW'(count_reg + QCW'(push.first) + QCW'(push.second)
                               - QCW'(pop));
        end
    end

    assign out_ch.valid             = count_reg != '0;
    assign out_ch.result_kind       = head.result_kind;
    assign out_ch.entry_index       = head.entry_index;
    assign out_ch.method            = head.method;
    assign out_ch.crc_value         = head.crc_value;
    assign out_ch.comp_bytes        = head.comp_bytes;
    assign out_ch.uncomp_bytes      = head.uncomp_bytes;
    assign out_ch.local_offset      = head.local_offset;
    assign out_ch.name_len          = head.name_len;
    assign out_ch.name_byte         = head.name_byte;
    assign out_ch.name_last         = head.name_last;
    assign out_ch.error_code        = head.error_code;

`ifndef SYNTH
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("result queue overflow");
    a_push_order : assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second record pushed without the first");
    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push.first) |=> count_reg == QCW'($past(count_reg) - QCW'(1)))
        else $error("queue count not reduced by a pop");
`endif

endmodule

/* hw/rtl/zip_central_directory_parser.sv */
// ----------------------------------------------------------------------------
// zip_central_directory_parser
// Streams a zip central directory one byte per item and emits entry records,
// name bytes, completion or a single error.
// ----------------------------------------------------------------------------
// The parser takes one item per clock while at least two slots of its
// four-entry result queue are free, so with the output side taking items
// freely it sustains one directory byte per cycle. A result is registered in
// the result queue before it reaches the output. A step that closes an entry
// may yield two results (the last name byte or the entry record, then
// completion or an error); both enter the queue in the same cycle and leave
// it one after the other. Configuration is sampled live by the parser and
// should be written only while no parse is in flight.
module zip_central_directory_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [zcdp_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [zcdp_pkg::CFG_DW-1:0]  cfg_wdata,
    zcdp_in_if.sink                      in_ch,
    zcdp_out_if.source                   out_ch
);
    import zcdp_pkg::*;

    push_t push;
    res_t  res0;
    res_t  res1;
    logic  space_ok;
    logic  accept;

    assign in_ch.ready = space_ok;
    assign accept      = in_ch.valid && space_ok;

    zcdp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .action    (in_ch.action),
        .data_byte (in_ch.data_byte),
        .push      (push),
        .res0      (res0),
        .res1      (res1)
    );

    zcdp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res0     (res0),
        .res1     (res1),
        .space_ok (space_ok),
        .out_ch   (out_ch)
    );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Feeds start and directory byte items to the central directory parser and
// follows the parse with a model of its own. The model predicts entry records,
// name bytes, completion and errors, and every result is compared field by
// field. Directed corner cases come first. Random directories follow, some of
// them with faults, cut short or restarted, under random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import zcdp_pkg::*;

    localparam logic ACT_BYTE = ~ACT_START;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } dir_item_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_wdata;

    zcdp_in_if  in_ch ();
    zcdp_out_if out_ch ();

    zip_central_directory_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // item traffic
    dir_item_t   dir_items [$];
    dir_item_t   next_item;
    res_t        due_records [$];
    logic [7:0]  dir_bytes [$];
    bit          item_waiting = 1'b0;
    bit          quiet = 1'b0;
    int          feed_gap = 0;
    int          drain_stall = 0;
    int          fed = 0;
    int          failures = 0;

    // parser model
    logic [31:0] avail_bytes = '0;
    logic [15:0] entry_limit = '0;
    phase_t      parse_phase = PH_IDLE;
    logic [5:0]  hdr_pos = '0;
    logic [33:0] consumed = '0;
    logic [15:0] cur_entry = '0;
    logic [31:0] sig_window = '0;
    logic [15:0] f_method = '0;
    logic [31:0] f_crc = '0;
    logic [31:0] f_comp = '0;
    logic [31:0] f_uncomp = '0;
    logic [31:0] f_local = '0;
    logic [15:0] f_name_len = '0;
    logic [15:0] f_extra_len = '0;
    logic [15:0] f_comment_len = '0;
    logic [15:0] name_left = '0;
    logic [16:0] skip_left = '0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic res_t blank_record(input logic [1:0] kind, input logic [15:0] idx);
        res_t r;
        r = '0;
        r.result_kind = kind;
        r.entry_index = idx;
        return r;
    endfunction

    function automatic void raise_error(input logic [15:0] idx, input logic [2:0] code);
        res_t r;
        r = blank_record(KIND_ERROR, idx);
        r.error_code = code;
        due_records = {due_records, r};
        parse_phase = PH_IDLE;
    endfunction

    function automatic void open_entry();
        if (cur_entry >= entry_limit)
        begin
            due_records = {due_records, blank_record(KIND_DONE, entry_limit)};
            parse_phase = PH_IDLE;
        end
        else if (64'(consumed) + 64'(HDR_LEN) > 64'(avail_bytes))
            raise_error(cur_entry, ERR_MALFORMED);
        else
        begin
            parse_phase = PH_HEADER;
            hdr_pos = '0;
            sig_window = '0;
        end
    endfunction

    function automatic void advance_entry();
        cur_entry = cur_entry + 16'd1;
        open_entry();
    endfunction

    function automatic void close_body();
        if (skip_left != 0)
            parse_phase = PH_SKIP;
        else
            advance_entry();
    endfunction

    function automatic void take_header_byte(input logic [7:0] b);
        int   k;
        res_t r;
        k = int'(hdr_pos);
        if (k <= HDR_SIG_LAST)
        begin
            sig_window = {b, sig_window[31:8]};
            if (k == HDR_SIG_LAST && sig_window != CENTRAL_SIG)
            begin
                raise_error(cur_entry, ERR_MALFORMED);
                return;
            end
        end
        if (k >= HDR_METHOD && k < HDR_METHOD + 2)
            f_method[8*(k-HDR_METHOD) +: 8] = b;
        if (k >= HDR_CRC && k < HDR_CRC + 4)
            f_crc[8*(k-HDR_CRC) +: 8] = b;
        if (k >= HDR_COMP && k < HDR_COMP + 4)
            f_comp[8*(k-HDR_COMP) +: 8] = b;
        if (k >= HDR_UNCOMP && k < HDR_UNCOMP + 4)
            f_uncomp[8*(k-HDR_UNCOMP) +: 8] = b;
        if (k >= HDR_NAME_LEN && k < HDR_NAME_LEN + 2)
            f_name_len[8*(k-HDR_NAME_LEN) +: 8] = b;
        if (k >= HDR_EXTRA_LEN && k < HDR_EXTRA_LEN + 2)
            f_extra_len[8*(k-HDR_EXTRA_LEN) +: 8] = b;
        if (k >= HDR_COMM_LEN && k < HDR_COMM_LEN + 2)
            f_comment_len[8*(k-HDR_COMM_LEN) +: 8] = b;
        if (k >= HDR_LOCAL_OFF && k < HDR_LOCAL_OFF + 4)
            f_local[8*(k-HDR_LOCAL_OFF) +: 8] = b;
        if (k != HDR_LAST)
        begin
            hdr_pos = hdr_pos + 6'd1;
            return;
        end
        if (f_comp == ZIP64_MARK || f_uncomp == ZIP64_MARK || f_local == ZIP64_MARK)
        begin
            raise_error(cur_entry, ERR_ZIP64);
            return;
        end
        if (64'(consumed) + 64'(f_name_len) > 64'(avail_bytes))
        begin
            raise_error(cur_entry, ERR_NAME);
            return;
        end
        r = blank_record(KIND_ENTRY, cur_entry);
        r.method = f_method;
        r.crc_value = f_crc;
        r.comp_bytes = f_comp;
        r.uncomp_bytes = f_uncomp;
        r.local_offset = f_local;
        r.name_len = f_name_len;
        due_records = {due_records, r};
        skip_left = {1'b0, f_extra_len} + {1'b0, f_comment_len};
        name_left = f_name_len;
        hdr_pos = '0;
        if (name_left != 0)
            parse_phase = PH_NAME;
        else
            close_body();
    endfunction

    function automatic void predict_item(input logic act, input logic [7:0] b);
        res_t r;
        if (act == ACT_START)
        begin
            parse_phase = PH_IDLE;
            hdr_pos = '0;
            consumed = '0;
            cur_entry = '0;
            sig_window = '0;
            name_left = '0;
            skip_left = '0;
            if (avail_bytes == 0)
                raise_error('0, ERR_OFFSET);
            else
                open_entry();
            return;
        end
        if (parse_phase == PH_IDLE)
            return;
        consumed = consumed + 34'd1;
        case (parse_phase)
            PH_HEADER: take_header_byte(b);
            PH_NAME:
            begin
                name_left = name_left - 16'd1;
                r = blank_record(KIND_NAME, cur_entry);
                r.name_len = f_name_len;
                r.name_byte = b;
                r.name_last = (name_left == 0);
                due_records = {due_records, r};
                if (name_left == 0)
                    close_body();
            end
            default:
            begin
                skip_left = skip_left - 17'd1;
                if (skip_left == 0)
                    advance_entry();
            end
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            failures++;
        end
    endfunction

    function automatic void check_result();
        res_t want;
        if (due_records.size() == 0)
        begin
            $error("result with nothing expected: kind %0d entry %0d",
                   out_ch.result_kind, out_ch.entry_index);
            failures++;
            return;
        end
        want = due_records.pop_front();
        check_field("result_kind", want.result_kind, out_ch.result_kind);
        check_field("entry_index", want.entry_index, out_ch.entry_index);
        check_field("method", want.method, out_ch.method);
        check_field("crc_value", want.crc_value, out_ch.crc_value);
        check_field("comp_bytes", want.comp_bytes, out_ch.comp_bytes);
        check_field("uncomp_bytes", want.uncomp_bytes, out_ch.uncomp_bytes);
        check_field("local_offset", want.local_offset, out_ch.local_offset);
        check_field("name_len", want.name_len, out_ch.name_len);
        check_field("name_byte", want.name_byte, out_ch.name_byte);
        check_field("name_last", want.name_last, out_ch.name_last);
        check_field("error_code", want.error_code, out_ch.error_code);
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // accepted items and results, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BYTES_AVAIL)
                    avail_bytes = cfg_wdata;
                else if (cfg_index == CFG_ENTRY_COUNT)
                    entry_limit = cfg_wdata[15:0];
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predict_item(in_ch.action, in_ch.data_byte);
                item_waiting = 1'b0;
            end
            if (out_ch.valid && out_ch.ready)
                check_result();
        end
    end

    // item feed and result stalls, driven at the falling edge
    always @(negedge clk)
    begin
        if (!item_waiting)
        begin
            if (feed_gap > 0)
            begin
                feed_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (dir_items.size() > 0)
            begin
                next_item = dir_items.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.action <= next_item.action;
                in_ch.data_byte <= next_item.data_byte;
                item_waiting = 1'b1;
                feed_gap = pick_gap();
            end
            else
                in_ch.valid <= 1'b0;
        end
        if (drain_stall > 0)
        begin
            drain_stall--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            drain_stall = pick_gap();
        end
    end

    function automatic void push_item(input logic act, input logic [7:0] b);
        dir_item_t it;
        it.action = act;
        it.data_byte = b;
        dir_items = {dir_items, it};
    endfunction

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (dir_items.size() != 0 || item_waiting || due_records.size() != 0)
            @(negedge clk);
    endtask

    // let the parser fall idle, closing any open parse with a bad signature
    task automatic settle();
        int k;
        wait_drained();
        repeat (8) @(negedge clk);
        if (parse_phase != PH_IDLE)
        begin
            push_item(ACT_START, 8'h00);
            for (k = 0; k < 4; k++)
                push_item(ACT_BYTE, 8'h00);
            wait_drained();
            repeat (8) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] size_value();
        case ($urandom_range(0, 29))
            0: return ZIP64_MARK;
            1: return 32'd0;
            2: return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    // appends one header with its body; returns 1 when the parse should stop there
    function automatic bit add_entry();
        logic [7:0]  hdr [46];
        logic [15:0] method, nlen, xlen, clen;
        logic [31:0] crc, csize, usize, loff;
        int          k, j, tail;
        bit          halts, huge;
        for (k = 0; k < 46; k++)
            hdr[k] = 8'($urandom);
        case ($urandom_range(0, 9))
            0: method = 16'd0;
            1: method = 16'd8;
            2: method = 16'hFFFF;
            default: method = 16'($urandom);
        endcase
        crc = $urandom;
        csize = size_value();
        usize = size_value();
        loff = size_value();
        huge = ($urandom_range(0, 11) == 0);
        if (huge)
        begin
            nlen = 16'($urandom);
            xlen = 16'($urandom);
            clen = 16'($urandom);
        end
        else
        begin
            nlen = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            xlen = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            clen = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        end
        for (k = 0; k < 4; k++)
        begin
            hdr[k] = CENTRAL_SIG[8*k +: 8];
            hdr[HDR_CRC + k] = crc[8*k +: 8];
            hdr[HDR_COMP + k] = csize[8*k +: 8];
            hdr[HDR_UNCOMP + k] = usize[8*k +: 8];
            hdr[HDR_LOCAL_OFF + k] = loff[8*k +: 8];
        end
        for (k = 0; k < 2; k++)
        begin
            hdr[HDR_METHOD + k] = method[8*k +: 8];
            hdr[HDR_NAME_LEN + k] = nlen[8*k +: 8];
            hdr[HDR_EXTRA_LEN + k] = xlen[8*k +: 8];
            hdr[HDR_COMM_LEN + k] = clen[8*k +: 8];
        end
        halts = huge || csize == ZIP64_MARK || usize == ZIP64_MARK || loff == ZIP64_MARK;
        if ($urandom_range(0, 11) == 0)
        begin
            j = $urandom_range(0, 3);
            hdr[j] = hdr[j] ^ 8'(1 << $urandom_range(0, 7));
            halts = 1'b1;
        end
        for (k = 0; k < 46; k++)
            dir_bytes = {dir_bytes, hdr[k]};
        if (huge)
            tail = $urandom_range(0, 24);
        else if (halts)
            tail = 0;
        else
            tail = int'(nlen) + int'(xlen) + int'(clen);
        for (k = 0; k < tail; k++)
            dir_bytes = {dir_bytes, 8'($urandom)};
        return halts;
    endfunction

    task automatic random_phase();
        int          n, i, dir_len, reps, rep, len;
        logic [15:0] count;
        logic [31:0] avail;
        bit          stopped;
        quiet = ($urandom_range(0, 6) == 0);
        dir_bytes.delete();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        stopped = 1'b0;
        for (i = 0; i < n && !stopped; i++)
            stopped = add_entry();
        n = i;
        dir_len = dir_bytes.size();
        case ($urandom_range(0, 19))
            0: count = 16'd0;
            1: count = 16'hFFFF;
            2, 3: count = 16'(n + $urandom_range(1, 2));
            4: count = (n > 0) ? 16'(n - 1) : 16'd0;
            default: count = 16'(n);
        endcase
        case ($urandom_range(0, 19))
            0: avail = 32'd0;
            1: avail = 32'hFFFF_FFFF;
            2, 3, 4: avail = $urandom_range(0, dir_len);
            default: avail = 32'(dir_len + $urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_BYTES_AVAIL, avail);
            write_reg(CFG_ENTRY_COUNT, {16'd0, count});
        end
        else
        begin
            write_reg(CFG_ENTRY_COUNT, {16'd0, count});
            write_reg(CFG_BYTES_AVAIL, avail);
        end
        reps = $urandom_range(1, 2);
        for (rep = 0; rep < reps; rep++)
        begin
            // stray bytes, mostly ignored
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) push_item(ACT_BYTE, 8'($urandom));
            push_item(ACT_START, 8'($urandom));
            len = dir_len;
            if (avail < 32'(dir_len))
                len = int'(avail) + $urandom_range(0, 4);
            if (len > dir_len)
                len = dir_len;
            // cut short, then abandoned by the next start
            if (rep < reps - 1 && $urandom_range(0, 1))
                len = $urandom_range(0, len);
            for (i = 0; i < len; i++)
                push_item(ACT_BYTE, dir_bytes[i]);
            fed += 1 + len;
        end
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_START;
        in_ch.data_byte = 8'h00;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // offset out of range, bytes while idle
        write_reg(CFG_BYTES_AVAIL, 32'd0);
        write_reg(CFG_ENTRY_COUNT, 32'h0000_FFFF);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_START, 8'h00);
        push_item(ACT_BYTE, 8'h00);
        settle();

        // header does not fit
        write_reg(CFG_BYTES_AVAIL, 32'd45);
        write_reg(CFG_ENTRY_COUNT, 32'd1);
        push_item(ACT_START, 8'hFF);
        settle();

        // zero entries
        write_reg(CFG_BYTES_AVAIL, 32'hFFFF_FFFF);
        write_reg(CFG_ENTRY_COUNT, 32'd0);
        push_item(ACT_START, 8'h00);
        settle();

        // bad signature, start while busy
        write_reg(CFG_ENTRY_COUNT, 32'h0000_FFFF);
        push_item(ACT_START, 8'h00);
        push_item(ACT_BYTE, 8'h50);
        push_item(ACT_BYTE, 8'h4b);
        push_item(ACT_BYTE, 8'h01);
        push_item(ACT_BYTE, 8'h03);
        push_item(ACT_START, 8'h00);
        push_item(ACT_BYTE, 8'h50);
        push_item(ACT_BYTE, 8'h4b);
        push_item(ACT_START, 8'h00);
        push_item(ACT_BYTE, 8'h50);
        push_item(ACT_BYTE, 8'h4b);
        push_item(ACT_BYTE, 8'h01);
        push_item(ACT_BYTE, 8'h02);
        settle();
        push_item(ACT_BYTE, 8'hAA);
        push_item(ACT_BYTE, 8'h55);
        settle();

        while (fed < 1300)
            random_phase();
        settle();

        if (failures == 0)
            $display("zip_central_directory_parser test passed");
        else
            $display("zip_central_directory_parser test failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("zip_central_directory_parser test failed");
        $finish;
    end

endmodule
